>>> hdl/knc_pkg.sv
// knc_pkg: shared constants, code values and controller/datapath structs
// for the k-means nearest-centroid block. No dependencies.

package knc_pkg;

  // default sizes, handed to the top level parameters
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_FEATURES = 32;
  localparam int DEF_VALUE_BITS   = 16;

  // fixed field widths
  localparam int MODE_BITS      = 2;
  localparam int CINDEX_BITS    = 4;
  localparam int FINDEX_BITS    = 5;
  localparam int CC_BITS        = 5;
  localparam int FC_BITS        = 6;
  localparam int DIST_BITS      = 31;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [DIST_BITS-1:0] INITIAL_BOUND = 31'h4000_0000;

  typedef logic [MODE_BITS-1:0] mode_t;
  localparam mode_t MODE_COORD   = 2'd0;
  localparam mode_t MODE_ID      = 2'd1;
  localparam mode_t MODE_FEATURE = 2'd2;

  typedef logic [CFG_INDEX_BITS-1:0] reg_index_t;
  localparam reg_index_t REG_CLUSTER_COUNT = 2'd0;
  localparam reg_index_t REG_FEATURE_COUNT = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;       // request channel may be taken this cycle
    logic k_clear;        // restart the centroid counter
    logic issue;          // start one subtract-square-add for centroid k
    logic step_features;  // one feature done, advance or close the point
    logic scan_start;     // reset running minimum, restart counter
    logic compare;        // compare centroid k against running minimum
    logic emit;           // move the answer to the output register
  } knc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_feature;     // pending request carries a point feature
    logic k_end;          // counter reached the active centroid count
    logic pipe_busy;
    logic last_feature;   // current feature completes the point
    logic out_full;       // output register cannot take a new result
  } knc_stat_t;

endpackage

>>> hdl/knc_if.sv
// knc_if: valid/ready channel interfaces for requests, results and
// configuration writes. Depends on knc_pkg.

interface knc_in_if
  import knc_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic [MODE_BITS-1:0]   mode;
  logic [CINDEX_BITS-1:0] cluster_index;
  logic [FINDEX_BITS-1:0] feature_index;
  logic [VALUE_BITS-1:0]  value;

  modport source (output valid, mode, cluster_index, feature_index, value, input ready);
  modport sink   (input valid, mode, cluster_index, feature_index, value, output ready);
endinterface

interface knc_out_if
  import knc_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_BITS:0]  cluster_id;
  logic [DIST_BITS-1:0]        min_distance;

  modport source (output valid, cluster_id, min_distance, input ready);
  modport sink   (input valid, cluster_id, min_distance, output ready);
endinterface

interface knc_cfg_if
  import knc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/knc_ctrl.sv
// knc_ctrl: sequencer for load requests, per-feature accumulation,
// minimum scan and result hand-off. Depends on knc_pkg.

module knc_ctrl
  import knc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  knc_stat_t stat,
  output knc_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACCUM = 5'b00010,
    S_DRAIN = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid && stat.in_feature) begin
          cmd.k_clear = 1'b1;
          state_next  = S_ACCUM;
        end
      end
      S_ACCUM: begin
        if (stat.k_end) begin
          state_next = S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.step_features = 1'b1;
          if (stat.last_feature) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (stat.k_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.compare = 1'b1;
        end
      end
      S_EMIT: begin
        if (!stat.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/knc_datapath.sv
// knc_datapath: centroid memory, id table, accumulators, shared
// subtract-square-add pipeline, minimum tracker, config and output registers.
// Depends on knc_pkg and knc_if.

module knc_datapath
  import knc_pkg::*;
#(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  knc_in_if.sink    items,
  knc_out_if.source results,
  knc_cfg_if.sink   cfg,
  input  knc_cmd_t  cmd,
  output knc_stat_t stat
);

  localparam int MEM_DEPTH = MAX_CLUSTERS * MAX_FEATURES;
  localparam int AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int IW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int KW    = $clog2(MAX_CLUSTERS + 1);
  localparam int ACC_W = 2 * VALUE_BITS + FW + 1;
  localparam int CMP_W = (ACC_W > DIST_BITS) ? ACC_W : DIST_BITS;

  // configuration
  logic [CC_BITS-1:0] cluster_count;
  logic [FC_BITS-1:0] feature_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= '0;
      feature_count <= FC_BITS'(1);
    end else if (cfg.valid) begin
      if (cfg.index == REG_CLUSTER_COUNT) begin
        cluster_count <= cfg.data[CC_BITS-1:0];
      end else if (cfg.index == REG_FEATURE_COUNT) begin
        feature_count <= cfg.data[FC_BITS-1:0];
      end
    end
  end

  // effective counts
  logic [KW-1:0]      nk;
  logic [FC_BITS:0]   nf;

  always_comb begin
    if (32'(cluster_count) > 32'(MAX_CLUSTERS)) begin
      nk = KW'(MAX_CLUSTERS);
    end else begin
      nk = KW'(cluster_count);
    end
    if (feature_count == '0) begin
      nf = (FC_BITS+1)'(1);
    end else if (32'(feature_count) > 32'(MAX_FEATURES)) begin
      nf = (FC_BITS+1)'(MAX_FEATURES);
    end else begin
      nf = {1'b0, feature_count};
    end
  end

  // request decode
  logic take;
  logic ci_ok, fi_ok;

  assign items.ready = cmd.in_ready;
  assign take  = items.valid && cmd.in_ready;
  assign ci_ok = 32'(items.cluster_index) < 32'(MAX_CLUSTERS);
  assign fi_ok = 32'(items.feature_index) < 32'(MAX_FEATURES);

  logic [VALUE_BITS-1:0] feat;

  always_ff @(posedge clk) begin
    if (take) begin
      feat <= items.value;
    end
  end

  // centroid counter shared by accumulate and scan
  logic [KW-1:0] k;
  logic [IW-1:0] k_idx;

  assign k_idx = k[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.k_clear || cmd.scan_start) begin
      k <= '0;
    end else if (cmd.issue || cmd.compare) begin
      k <= k + KW'(1);
    end
  end

  // features seen in the current point
  logic [FC_BITS-1:0] features_seen;
  logic               last_feature;

  assign last_feature = ({1'b0, features_seen} + (FC_BITS+1)'(1)) >= nf;

  always_ff @(posedge clk) begin
    if (rst) begin
      features_seen <= '0;
    end else if (cmd.step_features) begin
      features_seen <= last_feature ? '0 : features_seen + FC_BITS'(1);
    end
  end

  // centroid coordinate memory, one write and one registered read
  logic [VALUE_BITS-1:0] coord_mem [MEM_DEPTH];
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  assign wr_addr = AW'(items.cluster_index) * AW'(MAX_FEATURES) + AW'(items.feature_index);
  assign rd_addr = AW'(k_idx) * AW'(MAX_FEATURES) + AW'(features_seen[FW-1:0]);

  always_ff @(posedge clk) begin
    if (take && items.mode == MODE_COORD && ci_ok && fi_ok) begin
      coord_mem[wr_addr] <= items.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= coord_mem[rd_addr];
  end

  // centroid ids
  logic [VALUE_BITS-1:0] ids [MAX_CLUSTERS];

  always_ff @(posedge clk) begin
    if (take && items.mode == MODE_ID && ci_ok) begin
      ids[IW'(items.cluster_index)] <= items.value;
    end
  end

  // subtract-square-add pipeline
  logic                    s1_valid, s2_valid, s3_valid;
  logic [IW-1:0]           s1_idx, s2_idx, s3_idx;
  logic [VALUE_BITS-1:0]   absdiff;
  logic [2*VALUE_BITS-1:0] sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= k_idx;
    s2_idx  <= s1_idx;
    s3_idx  <= s2_idx;
    absdiff <= (feat >= rd_data) ? feat - rd_data : rd_data - feat;
    sq      <= absdiff * absdiff;
  end

  // distance accumulators, cleared when a result leaves
  logic [ACC_W-1:0] acc [MAX_CLUSTERS];

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        acc[i] <= '0;
      end
    end else if (s3_valid) begin
      acc[s3_idx] <= acc[s3_idx] + ACC_W'(sq);
    end
  end

  // running minimum
  logic [DIST_BITS-1:0]  best;
  logic [VALUE_BITS:0]   best_id;
  logic                  below;

  assign below = CMP_W'(acc[k_idx]) < CMP_W'(best);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best    <= INITIAL_BOUND;
      best_id <= '1;
    end else if (cmd.compare && below) begin
      best    <= DIST_BITS'(acc[k_idx]);
      best_id <= {1'b0, ids[k_idx]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.cluster_id   <= best_id;
      results.min_distance <= best;
    end
  end

  always_comb begin
    stat.in_valid     = items.valid;
    stat.in_feature   = items.mode == MODE_FEATURE;
    stat.k_end        = k == nk;
    stat.pipe_busy    = s1_valid || s2_valid || s3_valid;
    stat.last_feature = last_feature;
    stat.out_full     = results.valid && !results.ready;
  end

endmodule

>>> hdl/kmeans_nearest_centroid.sv
// kmeans_nearest_centroid: one request at a time. A point feature makes one pass of the
// shared subtract-square-add pipeline per active centroid (nk = active centroids), then
// waits for the pipeline to drain. The last feature of a point is followed by the minimum
// scan over the nk centroids; the result then sits in an output register while new requests
// are taken. Synchronous active-high reset clears counters, accumulators and the output valid
// flag and sets config to cluster count 0, feature count 1; centroid storage is not cleared.

module kmeans_nearest_centroid
  import knc_pkg::*;
#(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  knc_in_if.sink    items,
  knc_out_if.source results,
  knc_cfg_if.sink   cfg
);

  knc_cmd_t  cmd;
  knc_stat_t stat;

  knc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  knc_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_FEATURES (MAX_FEATURES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule
